// ===== src/qidt_pkg.sv =====
// Shared types and constants for the query ID translation table.
`timescale 1ns / 1ps

package qidt_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

  localparam logic       REQ_ALLOC   = 1'b0;
  localparam logic       REQ_RELEASE = 1'b1;
  localparam logic [7:0] ID_FAIL     = 8'hFF;

  typedef struct packed {
    logic [15:0] query_id;
    logic [31:0] addr;
    logic [15:0] port;
    logic [32:0] expiry;
    logic [63:0] key;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             set_done;
    logic [IDX_W-1:0] done_addr;
  } store_cmd_t;

endpackage

// ===== src/qidt_match.sv =====
// Replacement test applied to one stored entry during a full-table scan.
`timescale 1ns / 1ps

module qidt_match
  import qidt_pkg::*;
(
  input  entry_t      entry,
  input  logic        done,
  input  logic [31:0] now_seconds,
  input  logic [15:0] query_id,
  input  logic [63:0] name_key,
  output logic        hit
);

  logic expired;
  logic superseded;

  assign expired    = entry.expiry < {1'b0, now_seconds};
  assign superseded = (entry.query_id < query_id) && (entry.key == name_key);
  assign hit        = done || expired || superseded;

endmodule

// ===== src/qidt_store.sv =====
// Entry memory with registered read, plus per-slot done flags.
`timescale 1ns / 1ps

module qidt_store
  import qidt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  store_cmd_t cmd,
  input  entry_t     wr_data,
  output entry_t     rd_data,
  output logic       rd_done
);

  entry_t                mem [TABLE_SIZE];
  logic   [TABLE_SIZE-1:0] done_r;
  entry_t                rd_data_r;
  logic                  rd_done_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
      rd_done_r <= done_r[cmd.rd_addr];
    end
  end

  // a fresh fill clears done; release sets it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else begin
      if (cmd.wr_en) begin
        done_r[cmd.wr_addr] <= 1'b0;
      end
      if (cmd.set_done) begin
        done_r[cmd.done_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_done = rd_done_r;

endmodule

// ===== src/query_id_translation_table.sv =====
// Top level: request sequencer, result register and table instance.
`timescale 1ns / 1ps

// Query ID translation table. Allocate (in_req_type 0) stores the client's query
// ID, address, port, expiry (now + lifetime) and name key in a slot and returns
// the slot index as out_new_id. While the table has free slots the next one is
// appended. Once all TABLE_SIZE slots are in use, the slots are read one per
// cycle from index 0 through the single read port of the entry memory, and the
// first one that is done, expired or superseded by the same name key with a
// smaller stored ID is overwritten; a scan that finds nothing reports
// out_granted 0 with out_new_id 0xFF. Release (in_req_type 1) returns the stored
// fields of slot in_slot_index and marks it done if that slot is below the count
// of used slots; otherwise it reports out_granted 0 with zeroed fields. One item
// is in progress at a time; in_ready is low while it is. A finished result waits
// until the output register is free; once it is in the output register, the
// next item is accepted while it waits there.

module query_id_translation_table
  import qidt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [15:0] in_query_id,
  input  logic [31:0] in_client_addr,
  input  logic [15:0] in_client_port,
  input  logic [15:0] in_lifetime,
  input  logic [31:0] in_now_seconds,
  input  logic [63:0] in_name_key,
  input  logic [7:0]  in_slot_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_granted,
  output logic [7:0]  out_new_id,
  output logic [15:0] out_orig_id,
  output logic [31:0] out_orig_addr,
  output logic [15:0] out_orig_port
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_DISPATCH = 5'b00010,
    ST_REL_WAIT = 5'b00100,
    ST_SCAN     = 5'b01000,
    ST_FINISH   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // latched request
  logic             req_type_r;
  entry_t           req_entry_r;
  logic [31:0]      req_now_r;
  logic [IDX_W-1:0] req_slot_r;

  logic [CNT_W-1:0] used_count_r;
  logic             full;
  logic             rel_in_range;

  logic [IDX_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic             chk_vld_r;

  // result waiting for the output register
  logic        res_granted_r;
  logic [7:0]  res_new_id_r;
  logic [15:0] res_orig_id_r;
  logic [31:0] res_orig_addr_r;
  logic [15:0] res_orig_port_r;

  logic        out_valid_r;
  logic        out_granted_r;
  logic [7:0]  out_new_id_r;
  logic [15:0] out_orig_id_r;
  logic [31:0] out_orig_addr_r;
  logic [15:0] out_orig_port_r;

  store_cmd_t cmd;
  entry_t     rd_data;
  logic       rd_done;
  logic       hit;
  logic       in_acc;
  logic       out_free;
  logic       append;
  logic       scan_hit;
  logic       scan_last;

  assign in_acc       = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign full         = used_count_r == CNT_W'(TABLE_SIZE);
  assign rel_in_range = {1'b0, req_slot_r} < used_count_r;
  assign append       = (state_r == ST_DISPATCH) && (req_type_r == REQ_ALLOC) && !full;
  assign scan_hit     = (state_r == ST_SCAN) && chk_vld_r && hit;
  assign scan_last    = chk_idx_r == IDX_W'(TABLE_SIZE - 1);

  qidt_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .wr_data (req_entry_r),
    .rd_data (rd_data),
    .rd_done (rd_done)
  );

  qidt_match u_match (
    .entry       (rd_data),
    .done        (rd_done),
    .now_seconds (req_now_r),
    .query_id    (req_entry_r.query_id),
    .name_key    (req_entry_r.key),
    .hit         (hit)
  );

  always_comb begin
    cmd           = '0;
    cmd.wr_en     = append || scan_hit;
    cmd.wr_addr   = append ? used_count_r[IDX_W-1:0] : chk_idx_r;
    cmd.rd_en     = (state_r == ST_SCAN) ||
                    ((state_r == ST_DISPATCH) && (req_type_r == REQ_RELEASE));
    cmd.rd_addr   = (state_r == ST_SCAN) ? scan_idx_r : req_slot_r;
    cmd.set_done  = (state_r == ST_REL_WAIT) && rel_in_range;
    cmd.done_addr = req_slot_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (req_type_r == REQ_RELEASE) state_nxt = ST_REL_WAIT;
        else if (full)                 state_nxt = ST_SCAN;
        else                           state_nxt = ST_FINISH;
      end
      ST_REL_WAIT: state_nxt = ST_FINISH;
      ST_SCAN: begin
        if (chk_vld_r && (hit || scan_last)) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_count_r <= '0;
      chk_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (append) begin
        used_count_r <= used_count_r + CNT_W'(1);
      end
      if (state_r == ST_DISPATCH) begin
        chk_vld_r <= 1'b0;
      end else if (state_r == ST_SCAN) begin
        chk_vld_r <= 1'b1;
      end
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_type_r           <= in_req_type;
      req_entry_r.query_id <= in_query_id;
      req_entry_r.addr     <= in_client_addr;
      req_entry_r.port     <= in_client_port;
      req_entry_r.expiry   <= {1'b0, in_now_seconds} + {17'd0, in_lifetime};
      req_entry_r.key      <= in_name_key;
      req_now_r            <= in_now_seconds;
      req_slot_r           <= in_slot_index;
    end

    // scan pipeline: address issued one cycle, checked the next
    if (state_r == ST_DISPATCH) begin
      scan_idx_r <= '0;
    end else if (state_r == ST_SCAN) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
      chk_idx_r  <= scan_idx_r;
    end

    if (append) begin
      res_granted_r   <= 1'b1;
      res_new_id_r    <= used_count_r[IDX_W-1:0];
      res_orig_id_r   <= '0;
      res_orig_addr_r <= '0;
      res_orig_port_r <= '0;
    end else if (state_r == ST_SCAN && chk_vld_r) begin
      res_granted_r   <= hit;
      res_new_id_r    <= hit ? chk_idx_r : ID_FAIL;
      res_orig_id_r   <= '0;
      res_orig_addr_r <= '0;
      res_orig_port_r <= '0;
    end else if (state_r == ST_REL_WAIT) begin
      res_granted_r   <= rel_in_range;
      res_new_id_r    <= '0;
      res_orig_id_r   <= rel_in_range ? rd_data.query_id : 16'd0;
      res_orig_addr_r <= rel_in_range ? rd_data.addr : 32'd0;
      res_orig_port_r <= rel_in_range ? rd_data.port : 16'd0;
    end

    if (state_r == ST_FINISH && out_free) begin
      out_granted_r   <= res_granted_r;
      out_new_id_r    <= res_new_id_r;
      out_orig_id_r   <= res_orig_id_r;
      out_orig_addr_r <= res_orig_addr_r;
      out_orig_port_r <= res_orig_port_r;
    end
  end

  assign in_ready      = state_r == ST_IDLE;
  assign out_valid     = out_valid_r;
  assign out_granted   = out_granted_r;
  assign out_new_id    = out_new_id_r;
  assign out_orig_id   = out_orig_id_r;
  assign out_orig_addr = out_orig_addr_r;
  assign out_orig_port = out_orig_port_r;

endmodule
